/* rtl/int_sample_to_float32_fields_top_defines.svh */
// Assertion macros used by the checker file.
`ifndef INT_SAMPLE_TO_FLOAT32_FIELDS_TOP_DEFINES_SVH
`define INT_SAMPLE_TO_FLOAT32_FIELDS_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ISF_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ISF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/isf_pkg.sv */
package isf_pkg;

  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned EXP_W    = 8;
  localparam int unsigned MANT_W   = 23;
  localparam int unsigned SHIFT_W  = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  // Magnitude thresholds of the conversion
  localparam logic [SAMPLE_W-1:0] BIG_LIMIT  = 32'h0100_0000;
  localparam logic [SAMPLE_W-1:0] BIG_BITS   = 32'h0F00_0000;
  localparam logic [SAMPLE_W-1:0] HIDDEN_BIT = 32'h0080_0000;

  // Largest right shift a big magnitude can need to clear bits 24..27
  localparam int unsigned MAX_RSHIFT = 8;
  localparam int unsigned RSHIFT_W   = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRE_SHIFT = 2'd0,
    CFG_MAX_EXP   = 2'd1,
    CFG_FILL_ONES = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [SHIFT_W-1:0] pre_shift;
    logic [EXP_W-1:0]   max_exp;
    logic               fill_ones;
  } isf_cfg_t;

  typedef struct packed {
    logic                zero;
    logic                sign;
    logic [SAMPLE_W-1:0] mag;
  } isf_prep_t;

  typedef struct packed {
    logic              sign_bit;
    logic [EXP_W-1:0]  exponent;
    logic [MANT_W-1:0] mantissa;
  } isf_res_t;

endpackage

/* rtl/isf_if.sv */
// Input sample channel
interface isf_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample;
  logic               last_in;

  modport source (output valid, output sample, output last_in, input ready);
  modport sink   (input valid, input sample, input last_in, output ready);
endinterface

// Float field result channel
interface isf_out_if;
  logic        valid;
  logic        ready;
  logic        sign_bit;
  logic [7:0]  exponent;
  logic [22:0] mantissa;
  logic        last_out;

  modport source (output valid, output sign_bit, output exponent, output mantissa,
                  output last_out, input ready);
  modport sink   (input valid, input sign_bit, input exponent, input mantissa,
                  input last_out, output ready);
endinterface

/* rtl/isf_prep.sv */
module isf_prep (
  input  logic signed [31:0]                sample_i,
  input  logic [isf_pkg::SHIFT_W-1:0]       pre_shift_i,
  output isf_pkg::isf_prep_t                prep_o
);
  import isf_pkg::*;

  logic [SAMPLE_W-1:0] shifted;

  // Pre-shift with wrap, then split into sign and magnitude
  always_comb begin
    shifted     = SAMPLE_W'(unsigned'(sample_i)) << pre_shift_i;
    prep_o.zero = (sample_i == '0);
    prep_o.sign = shifted[SAMPLE_W-1];
    prep_o.mag  = shifted[SAMPLE_W-1] ? (~shifted + SAMPLE_W'(1)) : shifted;
  end

endmodule

/* rtl/isf_norm.sv */
module isf_norm (
  input  isf_pkg::isf_prep_t prep_i,
  input  isf_pkg::isf_cfg_t  cfg_i,
  output isf_pkg::isf_res_t  res_o
);
  import isf_pkg::*;

  logic [RSHIFT_W-1:0] rsh;
  logic [SAMPLE_W-1:0] mag_r;
  logic [4:0]          lz;
  logic                small_zero;
  logic                lz_fits;
  logic [EXP_W-1:0]    exp_m1;
  logic [4:0]          cnt;
  logic [MANT_W-1:0]   fill;

  // Find the smallest right shift that clears bits 24..27
  always_comb begin
    rsh = RSHIFT_W'(MAX_RSHIFT);
    for (int k = MAX_RSHIFT; k >= 0; k--) begin
      if (((prep_i.mag >> k) & BIG_BITS) == '0) rsh = RSHIFT_W'(k);
    end
    mag_r = prep_i.mag >> rsh;
  end

  // Count leading zeros from the hidden bit position downward
  always_comb begin
    lz = '0;
    for (int i = 0; i <= MANT_W; i++) begin
      if (prep_i.mag[i]) lz = 5'(MANT_W - i);
    end
    small_zero = (prep_i.mag[MANT_W:0] == '0);
  end

  // Left normalization stops once the exponent would reach zero
  always_comb begin
    lz_fits = !small_zero && ({3'b000, lz} < cfg_i.max_exp);
    exp_m1  = cfg_i.max_exp - EXP_W'(1);
    if (lz_fits) begin
      cnt = lz;
    end else if (exp_m1 >= EXP_W'(MANT_W)) begin
      cnt = 5'(MANT_W);
    end else begin
      cnt = exp_m1[4:0];
    end
    fill = cfg_i.fill_ones ? ~({MANT_W{1'b1}} << cnt) : '0;
  end

  // Select the result for zero, big and small magnitudes
  always_comb begin
    res_o.sign_bit = prep_i.sign;
    if (prep_i.zero) begin
      res_o = '0;
    end else if (prep_i.mag >= BIG_LIMIT) begin
      res_o.exponent = cfg_i.max_exp + EXP_W'(rsh);
      res_o.mantissa = mag_r[MANT_W-1:0];
    end else if (cfg_i.max_exp == '0) begin
      res_o.exponent = '0;
      res_o.mantissa = prep_i.mag[MANT_W-1:0];
    end else begin
      res_o.exponent = lz_fits ? (cfg_i.max_exp - EXP_W'(lz)) : '0;
      res_o.mantissa = (prep_i.mag[MANT_W-1:0] << cnt) | fill;
    end
  end

endmodule

/* rtl/int_sample_to_float32_fields_top.sv */
// Integer sample to single-precision float fields.
//
// in_i carries one signed 32-bit sample and an end-of-block flag per
// transfer; out_o returns the sign, biased exponent and mantissa fields with
// the flag copied through. Both channels transfer on valid and ready high.
// The cfg_* port writes pre_shift, max_exponent and fill_ones by index
// 0, 1 and 2; write only while no item is in flight.
//
// The sample lands in the input register, passes the pre-shift, magnitude,
// leading-zero count and normalizing shifts, and lands in the result
// register. One item per cycle is sustained while the receiver keeps ready
// high; the input and result registers form a two-entry pipeline.
//
// Reset clears both pipeline valid bits and all configuration to zero.
// When the receiver holds ready low the result register keeps its value, the
// input register still takes one more item, and in_i.ready drops only once
// both registers are full.
module int_sample_to_float32_fields_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  isf_in_if.sink                         in_i,
  isf_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [isf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [isf_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import isf_pkg::*;

  isf_cfg_t            cfg_q;
  logic                s0_valid_q;
  logic [SAMPLE_W-1:0] s0_sample_q;
  logic                s0_last_q;
  logic                s1_valid_q;
  isf_res_t            s1_res_q;
  logic                s1_last_q;
  logic                s0_ready;
  logic                s1_ready;
  isf_prep_t           prep;
  isf_res_t            res;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PRE_SHIFT: cfg_q.pre_shift <= cfg_wdata_i[SHIFT_W-1:0];
        CFG_MAX_EXP:   cfg_q.max_exp   <= cfg_wdata_i[EXP_W-1:0];
        CFG_FILL_ONES: cfg_q.fill_ones <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Advance each stage when the one after it has room
  assign s1_ready   = !s1_valid_q || out_o.ready;
  assign s0_ready   = !s0_valid_q || s1_ready;
  assign in_i.ready = s0_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      if (s0_ready) s0_valid_q <= in_i.valid;
      if (s1_ready) s1_valid_q <= s0_valid_q;
    end
  end

  // Capture the sample on an input transfer
  always_ff @(posedge clk_i) begin
    if (s0_ready && in_i.valid) begin
      s0_sample_q <= unsigned'(in_i.sample);
      s0_last_q   <= in_i.last_in;
    end
  end

  isf_prep u_prep (
    .sample_i    (signed'(s0_sample_q)),
    .pre_shift_i (cfg_q.pre_shift),
    .prep_o      (prep)
  );

  isf_norm u_norm (
    .prep_i (prep),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // Hold the result until the receiver takes it
  always_ff @(posedge clk_i) begin
    if (s1_ready && s0_valid_q) begin
      s1_res_q  <= res;
      s1_last_q <= s0_last_q;
    end
  end

  assign out_o.valid    = s1_valid_q;
  assign out_o.sign_bit = s1_res_q.sign_bit;
  assign out_o.exponent = s1_res_q.exponent;
  assign out_o.mantissa = s1_res_q.mantissa;
  assign out_o.last_out = s1_last_q;

endmodule

/* rtl/isf_checker.sv */
`include "int_sample_to_float32_fields_top_defines.svh"

module isf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        sign_bit_i,
  input logic [7:0]  exponent_i,
  input logic [22:0] mantissa_i,
  input logic        last_out_i
);

  logic [1:0]  cnt_q;
  logic [1:0]  cnt_d;
  logic        in_xfer;
  logic        out_xfer;
  logic        out_stall;
  logic [32:0] out_word;

  assign in_xfer   = in_valid_i && in_ready_i;
  assign out_xfer  = out_valid_i && out_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;
  assign out_word  = {sign_bit_i, exponent_i, mantissa_i, last_out_i};

  // Track items accepted but not yet delivered
  always_comb begin
    cnt_d = cnt_q;
    if (in_xfer && !out_xfer) cnt_d = cnt_q + 2'd1;
    if (!in_xfer && out_xfer) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  `ISF_ASSERT_IMPL(a_depth, 1'b1, cnt_q <= 2'd2, "more than two items in flight")
  `ISF_ASSERT_IMPL(a_no_phantom, out_valid_i, cnt_q != 2'd0, "result with no item in flight")
  `ISF_ASSERT_IMPL(a_ready_empty, cnt_q != 2'd2, in_ready_i, "input stalled with room left")
  `ISF_ASSERT_NEXT(a_hold, out_stall, out_valid_i && $stable(out_word), "stalled result changed")

endmodule

bind int_sample_to_float32_fields_top isf_checker u_isf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .sign_bit_i  (out_o.sign_bit),
  .exponent_i  (out_o.exponent),
  .mantissa_i  (out_o.mantissa),
  .last_out_i  (out_o.last_out)
);

/* tb/tb_int_sample_to_float32_fields_top.sv */
`timescale 1ns / 1ps

module tb_int_sample_to_float32_fields_top;
  import isf_pkg::*;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned IDLE_PCT = 24;

  typedef struct {
    logic [31:0] sample;
    logic        last;
  } sample_item_t;

  typedef struct packed {
    isf_res_t fields;
    logic     last;
  } float_fields_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  isf_in_if  in_ch();
  isf_out_if out_ch();

  int_sample_to_float32_fields_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  sample_item_t  sample_queue[$];
  float_fields_t expected_fields[$];
  isf_cfg_t      cfg_shadow;
  sample_item_t  next_item;
  float_fields_t want;
  int unsigned   src_idle_pct = IDLE_PCT;
  int unsigned   sink_idle_pct = IDLE_PCT;
  int unsigned   quiet_cycles;
  int            errors;

  always #5 clk_i = ~clk_i;

  // Expected float fields of one sample under the current register settings
  function automatic float_fields_t predict_fields(logic [31:0] sample, logic last_flag);
    float_fields_t r;
    logic [31:0]   mag;
    int unsigned   expo;
    int unsigned   count;
    r = '0;
    r.last = last_flag;
    expo = cfg_shadow.max_exp;
    count = 0;
    mag = sample;
    if (mag == '0) begin
      expo = 0;
    end else begin
      mag = mag << cfg_shadow.pre_shift;
      if (mag[31]) begin
        r.fields.sign_bit = 1'b1;
        mag = -mag;
      end
      if (mag >= BIG_LIMIT) begin
        // shift right until bits 24..27 are clear
        while ((mag & BIG_BITS) != '0) begin
          mag = mag >> 1;
          expo++;
        end
      end else if (expo != 0) begin
        // normalize left, stopping at exponent zero
        while (expo != 0 && (mag & HIDDEN_BIT) == '0) begin
          expo--;
          if (expo != 0) begin
            count++;
            mag = mag << 1;
          end
        end
        if (count != 0 && cfg_shadow.fill_ones) begin
          if (count >= 32) mag = '1;
          else mag = mag | 32'((64'd1 << count) - 64'd1);
        end
      end
      r.fields.mantissa = mag[MANT_W-1:0];
    end
    r.fields.exponent = expo[EXP_W-1:0];
    return r;
  endfunction

  // Feed samples from the pending queue, holding each until its transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) expected_fields.push_back(predict_fields(in_ch.sample, in_ch.last_in));
      if (sample_queue.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        next_item = sample_queue.pop_front();
        in_ch.valid   <= 1'b1;
        in_ch.sample  <= next_item.sample;
        in_ch.last_in <= next_item.last;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Check each result transfer against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_fields.size() == 0) begin
          $display("%0t: unexpected result sign=%0d exp=%0d mant=%h last=%0d", $time,
                   out_ch.sign_bit, out_ch.exponent, out_ch.mantissa, out_ch.last_out);
          errors++;
        end else begin
          want = expected_fields.pop_front();
          if (out_ch.sign_bit !== want.fields.sign_bit) begin
            $display("%0t: sign_bit expected %0d actual %0d", $time,
                     want.fields.sign_bit, out_ch.sign_bit);
            errors++;
          end
          if (out_ch.exponent !== want.fields.exponent) begin
            $display("%0t: exponent expected %0d actual %0d", $time,
                     want.fields.exponent, out_ch.exponent);
            errors++;
          end
          if (out_ch.mantissa !== want.fields.mantissa) begin
            $display("%0t: mantissa expected %h actual %h", $time,
                     want.fields.mantissa, out_ch.mantissa);
            errors++;
          end
          if (out_ch.last_out !== want.last) begin
            $display("%0t: last_out expected %0d actual %0d", $time, want.last, out_ch.last_out);
            errors++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  // Count cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Write one register and mirror it in the shadow copy
  task automatic write_reg(cfg_idx_e idx, int unsigned value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= CFG_DATA_W'(value);
    case (idx)
      CFG_PRE_SHIFT: cfg_shadow.pre_shift = SHIFT_W'(value);
      CFG_MAX_EXP:   cfg_shadow.max_exp = EXP_W'(value);
      CFG_FILL_ONES: cfg_shadow.fill_ones = value[0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic apply_config(int unsigned shift, int unsigned max_exp, int unsigned fill);
    write_reg(CFG_PRE_SHIFT, shift);
    write_reg(CFG_MAX_EXP, max_exp);
    write_reg(CFG_FILL_ONES, fill);
  endtask

  // Hold until nothing is queued, in transfer or awaiting a result;
  // sample at the falling edge so the clocked updates have settled
  task automatic wait_drained();
    do @(negedge clk_i);
    while (sample_queue.size() != 0 || in_ch.valid || expected_fields.size() != 0);
  endtask

  // Field extremes, thresholds, the most negative value and shift-to-zero cases
  task automatic load_directed();
    logic [31:0] picks[12];
    picks = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h4000_0000, 32'h0080_0000, 32'h00FF_FFFF,
              32'h0100_0000, 32'h0FFF_FFFF, 32'h1000_0000, 32'hFF00_0001};
    foreach (picks[i]) sample_queue.push_back(sample_item_t'{picks[i], 1'(i % 2)});
  endtask

  // Random-width magnitudes of either sign, plus full-width noise, single bits and thresholds
  task automatic load_random(int unsigned n);
    logic [31:0]  v;
    int unsigned  w;
    sample_item_t it;
    for (int unsigned k = 0; k < n; k++) begin
      case ($urandom_range(0, 4))
        0: v = $urandom;
        1, 2: begin
          w = $urandom_range(0, 31);
          v = $urandom & ((32'd1 << w) - 32'd1);
          if ($urandom_range(0, 1) != 0) v = -v;
        end
        3: v = 32'd1 << $urandom_range(0, 31);
        default: v = (32'd1 << $urandom_range(20, 31)) - 32'($urandom_range(0, 2));
      endcase
      it.sample = v;
      it.last = 1'($urandom_range(0, 1));
      sample_queue.push_back(it);
    end
  endtask

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.sample  = '0;
    in_ch.last_in = 1'b0;
    out_ch.ready  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_PRE_SHIFT;
    cfg_wdata_i   = '0;
    cfg_shadow    = '0;
    errors        = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed samples, first with reset settings (no normalization)
    load_directed();
    wait_drained();
    apply_config(1, 150, 1);
    load_directed();
    wait_drained();

    // register extremes
    apply_config(31, 255, 1);
    load_random(35);
    wait_drained();
    apply_config(0, 255, 0);
    load_random(35);
    wait_drained();
    apply_config(31, 0, 0);
    load_random(35);
    wait_drained();
    apply_config(0, 0, 1);
    load_random(35);
    wait_drained();

    // back-to-back stretch with no idling on either side
    src_idle_pct = 0;
    sink_idle_pct = 0;
    apply_config($urandom_range(0, 3), $urandom_range(100, 160), 1);
    load_random(60);
    wait_drained();
    src_idle_pct = IDLE_PCT;
    sink_idle_pct = IDLE_PCT;

    // random settings, small shifts favored
    for (int p = 0; p < 4; p++) begin
      apply_config(($urandom_range(0, 1) != 0) ? $urandom_range(0, 3) : $urandom_range(0, 31),
                   $urandom_range(0, 255), $urandom_range(0, 1));
      load_random(50);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/isf_pkg.sv
rtl/isf_if.sv
rtl/isf_prep.sv
rtl/isf_norm.sv
rtl/int_sample_to_float32_fields_top.sv
rtl/isf_checker.sv
tb/tb_int_sample_to_float32_fields_top.sv
